[rtl/core/frame_window_duration_stats_unit_assert.svh]
// Assertion macros shared by the checker of the frame window duration statistics unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FRAME_WINDOW_DURATION_STATS_UNIT_ASSERT_SVH
`define FRAME_WINDOW_DURATION_STATS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FWDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FWDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fwds_pkg.sv]
// Package for the frame window duration statistics unit: field widths, register
// indexes, the sequencer state type and the structs passed between modules. No dependencies.
`default_nettype none

package fwds_pkg;

    localparam int DUR_W   = 48;
    localparam int FRAME_W = 32;
    localparam int TOTAL_W = 56;
    localparam int COUNT_W = 7;
    localparam int WIN_W   = 7;
    localparam int ENTRY_W = FRAME_W + DUR_W;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd60;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;

    localparam logic CFG_WINDOW_FRAMES = 1'b0;
    localparam logic CFG_OUTLIER_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CHK,
        S_APPEND,
        S_EV_RD,
        S_EV_CHK,
        S_RC_INIT,
        S_RC,
        S_DIV,
        S_FINISH
    } eng_state_t;

    typedef struct packed {
        logic             action;
        logic [DUR_W-1:0] duration;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
        logic [DUR_W-1:0]   max;
        logic [DUR_W-1:0]   min;
        logic [DUR_W-1:0]   average;
    } stats_t;

endpackage

`default_nettype wire

[rtl/core/fwds_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No package dependency.
`default_nettype none

module fwds_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/fwds_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// No package dependency.
`default_nettype none

module fwds_div #(
    parameter int DIVIDEND_W = 56,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits the divisor width.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/fwds_engine.sv]
// Ring sequencer: keeps the per-frame entries in RAM, evicts old frames and
// recomputes total, max, min and average. Uses fwds_pkg, fwds_ram and fwds_div.
`default_nettype none

module fwds_engine
    import fwds_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire item_t              item,
    input  wire logic [WIN_W-1:0]   window_frames,
    input  wire logic [DUR_W-1:0]   outlier_limit,
    input  wire logic               res_ready,
    output logic                    idle,
    output logic                    res_valid,
    output stats_t                  stats
);

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    eng_state_t          state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FRAME_W-1:0]  fc_reg, fc_next;
    logic [DUR_W-1:0]    dur_reg, dur_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   issue_reg, issue_next;
    logic                data_v_reg, data_v_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [DUR_W-1:0]    max_reg, max_next;
    logic [DUR_W-1:0]    min_reg, min_next;
    logic [FILL_W-1:0]   count_reg, count_next;
    logic [DUR_W-1:0]    avg_reg, avg_next;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [DUR_W-1:0]    rd_dur;
    logic [FRAME_W-1:0]  rd_frame;
    logic [PTR_W-1:0]    newest_slot;
    logic [PTR_W-1:0]    append_slot;
    logic [DUR_W:0]      add_sum;
    logic [DUR_W-1:0]    add_sat;
    logic [TOTAL_W:0]    acc_sum;
    logic [FRAME_W-1:0]  age;
    logic [FRAME_W-1:0]  win_clamped;
    logic                div_start;
    logic                div_done;
    logic [TOTAL_W-1:0]  div_quotient;
    logic [31:0]         count_wide;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Offset is at most the depth wherever the result is used, so one subtract folds the sum back.
    function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                   input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(base) + (FILL_W+1)'(off);
        if (sum >= (FILL_W+1)'(WINDOW_DEPTH))
        begin
            sum = sum - (FILL_W+1)'(WINDOW_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign rd_dur      = ram_rd_data[DUR_W-1:0];
    assign rd_frame    = ram_rd_data[ENTRY_W-1:DUR_W];
    assign newest_slot = ring_slot(head_reg, fill_reg - 1'b1);
    assign append_slot = ring_slot(head_reg, fill_reg);
    assign add_sum     = {1'b0, rd_dur} + {1'b0, dur_reg};
    assign add_sat     = add_sum[DUR_W] ? '1 : add_sum[DUR_W-1:0];
    assign acc_sum     = {1'b0, total_reg} + (TOTAL_W+1)'(rd_dur);
    assign age         = fc_reg - rd_frame;
    assign win_clamped = (32'(window_frames) > 32'(WINDOW_DEPTH)) ?
                         32'(WINDOW_DEPTH) : 32'(window_frames);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        fc_next     = fc_reg;
        dur_next    = dur_reg;
        rd_ptr_next = rd_ptr_reg;
        issue_next  = issue_reg;
        data_v_next = 1'b0;
        total_next  = total_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        count_next  = count_reg;
        avg_next    = avg_reg;
        ram_we      = 1'b0;
        ram_wr_addr = newest_slot;
        ram_wr_data = {fc_reg, dur_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        div_start   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dur_next = item.duration;
                    if (item.action)
                    begin
                        fc_next    = fc_reg + 1'b1;
                        state_next = S_EV_RD;
                    end
                    else if (fill_reg != '0)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = newest_slot;
                        state_next  = S_ADD_CHK;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_ADD_CHK:
            begin
                // An add in the newest entry's frame sums in place and keeps the statistics.
                if (rd_frame == fc_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = newest_slot;
                    ram_wr_data = {rd_frame, add_sat};
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                ram_we = 1'b1;
                if (fill_reg == FILL_W'(WINDOW_DEPTH))
                begin
                    // Full ring: the new entry takes the oldest entry's slot.
                    ram_wr_addr = head_reg;
                    head_next   = ptr_inc(head_reg);
                end
                else
                begin
                    ram_wr_addr = append_slot;
                    fill_next   = fill_reg + 1'b1;
                end
                state_next = S_EV_RD;
            end
            S_EV_RD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_RC_INIT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = head_reg;
                    state_next  = S_EV_CHK;
                end
            end
            S_EV_CHK:
            begin
                if (age >= win_clamped)
                begin
                    head_next  = ptr_inc(head_reg);
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_EV_RD;
                end
                else
                begin
                    state_next = S_RC_INIT;
                end
            end
            S_RC_INIT:
            begin
                total_next  = '0;
                max_next    = '0;
                min_next    = '1;
                count_next  = fill_reg;
                rd_ptr_next = head_reg;
                issue_next  = '0;
                state_next  = S_RC;
            end
            S_RC:
            begin
                // Reads are issued back to back; each entry is folded in the cycle after its read.
                if (issue_reg != fill_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_ptr_reg;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    issue_next  = issue_reg + 1'b1;
                    data_v_next = 1'b1;
                end
                if (data_v_reg && (rd_dur <= outlier_limit))
                begin
                    total_next = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
                    if (rd_dur > max_reg)
                    begin
                        max_next = rd_dur;
                    end
                    if (rd_dur < min_reg)
                    begin
                        min_next = rd_dur;
                    end
                end
                if ((issue_reg == fill_reg) && !data_v_reg)
                begin
                    if (fill_reg == '0)
                    begin
                        avg_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient[DUR_W-1:0];
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            fc_reg     <= '0;
            rd_ptr_reg <= '0;
            issue_reg  <= '0;
            data_v_reg <= 1'b0;
            total_reg  <= '0;
            max_reg    <= '0;
            min_reg    <= '1;
            count_reg  <= '0;
            avg_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            fc_reg     <= fc_next;
            rd_ptr_reg <= rd_ptr_next;
            issue_reg  <= issue_next;
            data_v_reg <= data_v_next;
            total_reg  <= total_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            count_reg  <= count_next;
            avg_reg    <= avg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg <= dur_next;
    end

    fwds_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fwds_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign count_wide    = 32'(count_reg);
    assign idle          = (state_reg == S_IDLE);
    assign stats.valid   = (count_reg != '0);
    assign stats.count   = (count_wide > 32'(COUNT_MAX)) ? COUNT_MAX : count_wide[COUNT_W-1:0];
    assign stats.total   = total_reg;
    assign stats.max     = max_reg;
    assign stats.min     = min_reg;
    assign stats.average = avg_reg;

endmodule

`default_nettype wire

[rtl/core/frame_window_duration_stats_unit.sv]
// Top level of the frame window duration statistics unit: configuration
// registers and the result register. Uses fwds_pkg and fwds_engine.
//
// Usage: an input beat (in_valid/in_ready) carries action and duration_us.
// Action 0 adds the duration to the current frame, action 1 advances the frame.
// Every input beat yields exactly one output beat (out_valid/out_ready) with
// count, total, max, min and truncated average over the kept frames.
// One item is processed at a time; in_ready is high while the sequencer is idle.
// An add that lands in the newest frame sums in place. An append or an advance
// evicts expired entries one by one, walks the kept entries through the RAM read
// port and then runs the serial divider. An empty window skips the divider and
// finishes after the last eviction.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, a further result is held in the sequencer until the
// output register frees up, and no new item is accepted meanwhile.
// Reset empties the ring, zeroes the frame counter and statistics but sets min
// to all ones, sets the window to 60 frames and the outlier limit to all ones.
// No RAM clearing pass is needed: only entries within the ring fill are ever read.
// Configuration writes take effect from the next item and must be made while idle.
`default_nettype none

module frame_window_duration_stats_unit
    import fwds_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic [DUR_W-1:0]   duration_us,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    stats_valid,
    output logic      [COUNT_W-1:0] entry_count,
    output logic      [TOTAL_W-1:0] total_us,
    output logic      [DUR_W-1:0]   max_us,
    output logic      [DUR_W-1:0]   min_us,
    output logic      [DUR_W-1:0]   average_us,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [DUR_W-1:0]   cfg_data
);

    logic [WIN_W-1:0] window_reg;
    logic [DUR_W-1:0] limit_reg;
    logic             out_valid_reg, out_valid_next;
    stats_t           out_stats_reg;
    logic             eng_idle;
    logic             eng_res_valid;
    logic             res_ready;
    logic             load;
    stats_t           eng_stats;
    item_t            item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            limit_reg  <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW_FRAMES: window_reg <= cfg_data[WIN_W-1:0];
                CFG_OUTLIER_LIMIT: limit_reg  <= cfg_data;
                default:           limit_reg  <= limit_reg;
            endcase
        end
    end

    assign item.action   = action;
    assign item.duration = duration_us;
    assign in_ready      = eng_idle;
    assign res_ready     = !out_valid_reg || out_ready;
    assign load          = eng_res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_stats_reg <= eng_stats;
        end
    end

    fwds_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_valid && eng_idle),
        .item          (item),
        .window_frames (window_reg),
        .outlier_limit (limit_reg),
        .res_ready     (res_ready),
        .idle          (eng_idle),
        .res_valid     (eng_res_valid),
        .stats         (eng_stats)
    );

    assign out_valid   = out_valid_reg;
    assign stats_valid = out_stats_reg.valid;
    assign entry_count = out_stats_reg.count;
    assign total_us    = out_stats_reg.total;
    assign max_us      = out_stats_reg.max;
    assign min_us      = out_stats_reg.min;
    assign average_us  = out_stats_reg.average;

endmodule

`default_nettype wire

[rtl/core/fwds_checker.sv]
// Port-level checker for the frame window duration statistics unit and its bind.
// Uses fwds_pkg and the assertion macros header.
`default_nettype none
`include "frame_window_duration_stats_unit_assert.svh"

module fwds_checker
    import fwds_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               stats_valid,
    input wire logic [COUNT_W-1:0] entry_count,
    input wire logic [TOTAL_W-1:0] total_us,
    input wire logic [DUR_W-1:0]   max_us,
    input wire logic [DUR_W-1:0]   min_us,
    input wire logic [DUR_W-1:0]   average_us
);

    // A stalled result beat must hold.
    `FWDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_us) && $stable(average_us), "result beat changed while stalled")

    // One item at a time: an accepted beat makes the input side busy.
    `FWDS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted while an item is in progress")

    `FWDS_ASSERT_IMPLY(a_valid_matches_count, out_valid, stats_valid == (entry_count != 7'd0), "stats_valid disagrees with entry_count")

    // An empty window reports the cleared statistics.
    `FWDS_ASSERT_IMPLY(a_empty_stats, out_valid && !stats_valid, (total_us == 56'd0) && (max_us == 48'd0) && (&min_us) && (average_us == 48'd0), "empty window with nonzero statistics")

endmodule

bind frame_window_duration_stats_unit fwds_checker u_fwds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stats_valid (stats_valid),
    .entry_count (entry_count),
    .total_us    (total_us),
    .max_us      (max_us),
    .min_us      (min_us),
    .average_us  (average_us)
);

`default_nettype wire
